/* src/lenav_pkg.sv */
// ----------------------------------------------------------------------------
// lenav_pkg
// Shared types and constants of the line editor with word navigation.
// ----------------------------------------------------------------------------
package lenav_pkg;

  // Line geometry
  localparam int LINE_CAPACITY = 62;
  localparam int POS_W         = $clog2(LINE_CAPACITY + 1);
  localparam int CHAR_W        = 7;
  localparam int FUNC_W        = 3;

  localparam logic [POS_W-1:0]  CAP_POS    = POS_W'(LINE_CAPACITY);
  localparam logic [CHAR_W-1:0] SPACE_CODE = 7'd32;
  localparam logic [CHAR_W-1:0] GLYPH_LOW  = 7'd32;
  localparam logic [CHAR_W-1:0] GLYPH_HIGH = 7'd126;

  // Command codes on the input stream
  localparam logic [FUNC_W-1:0] FUNC_INSERT     = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_DEL_CHAR   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DEL_WORD   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_LEFT       = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_RIGHT      = 3'd4;
  localparam logic [FUNC_W-1:0] FUNC_WORD_LEFT  = 3'd5;
  localparam logic [FUNC_W-1:0] FUNC_WORD_RIGHT = 3'd6;

  // Classified operation handed from the front to the back
  typedef enum logic [2:0] {
    OP_INSERT,
    OP_DEL_CHAR,
    OP_DEL_WORD,
    OP_LEFT,
    OP_RIGHT,
    OP_WORD_LEFT,
    OP_WORD_RIGHT,
    OP_NONE
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_PUT,
    ST_REMOVE,
    ST_EMIT
  } state_t;

endpackage

/* src/line_editor_word_navigation.sv */
// ----------------------------------------------------------------------------
// line_editor_word_navigation
// Edit line with character and word motion; streams the line after each
// command word.
// ----------------------------------------------------------------------------
//  channel | dir | tdata fields (low bit up)                        | tlast
//  s_*     | in  | func[2:0] new_char[9:3]                          | -
//  m_*     | out | column[5:0] glyph[12:6] at_cursor[13]            | last
//          |     | line_length[19:14] cursor_column[25:20]          |
//
//  Per command: a dispatch step, the edit, then one word a cycle for the line
//  while the output is ready (length cells, plus the end cell when the cursor
//  sits there), set by the single memory read port. Insert shifts the tail
//  one cell right, then places the character; deletes close the gap; word
//  scans walk the space map cell by cell in two phases.
//  Reset (rst, synchronous) empties the line; output stalls hold the result.
// ----------------------------------------------------------------------------
module line_editor_word_navigation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // func[2:0], new_char[9:3]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // column[5:0], glyph[12:6], at_cursor[13],
                                 // line_length[19:14], cursor_column[25:20]
  output logic        m_tlast
);

  logic            q_full;
  logic            q_push;
  lenav_pkg::cmd_t push_cmd;
  logic            q_pop;
  logic            q_valid;
  lenav_pkg::cmd_t head_cmd;

  lenav_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_cmd    (push_cmd)
  );

  lenav_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head_cmd (head_cmd)
  );

  lenav_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (head_cmd),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* src/lenav_front.sv */
// ----------------------------------------------------------------------------
// lenav_front
// Accepts command words and classifies them into back-end operations.
// ----------------------------------------------------------------------------
module lenav_front (
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [15:0]                  s_tdata,   // func[2:0], new_char[9:3]
  input  logic                         q_full,
  output logic                         q_push,
  output lenav_pkg::cmd_t              q_cmd
);

  logic [lenav_pkg::FUNC_W-1:0] func;
  logic [lenav_pkg::CHAR_W-1:0] ch;
  logic                         printable;

  assign func      = s_tdata[2:0];
  assign ch        = s_tdata[9:3];
  assign printable = (ch >= lenav_pkg::GLYPH_LOW) && (ch <= lenav_pkg::GLYPH_HIGH);

  // Take a word whenever the queue has room
  assign s_tready = ~q_full;
  assign q_push   = s_tvalid & ~q_full;

  // Map command code to an operation; drop non-printable inserts
  always_comb begin
    q_cmd.ch = ch;
    case (func)
      lenav_pkg::FUNC_INSERT:     q_cmd.op = printable ? lenav_pkg::OP_INSERT
                                                       : lenav_pkg::OP_NONE;
      lenav_pkg::FUNC_DEL_CHAR:   q_cmd.op = lenav_pkg::OP_DEL_CHAR;
      lenav_pkg::FUNC_DEL_WORD:   q_cmd.op = lenav_pkg::OP_DEL_WORD;
      lenav_pkg::FUNC_LEFT:       q_cmd.op = lenav_pkg::OP_LEFT;
      lenav_pkg::FUNC_RIGHT:      q_cmd.op = lenav_pkg::OP_RIGHT;
      lenav_pkg::FUNC_WORD_LEFT:  q_cmd.op = lenav_pkg::OP_WORD_LEFT;
      lenav_pkg::FUNC_WORD_RIGHT: q_cmd.op = lenav_pkg::OP_WORD_RIGHT;
      default:                    q_cmd.op = lenav_pkg::OP_NONE;
    endcase
  end

endmodule

/* src/lenav_cmd_queue.sv */
// ----------------------------------------------------------------------------
// lenav_cmd_queue
// Two-entry queue of classified commands between the front and the back.
// ----------------------------------------------------------------------------
module lenav_cmd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  lenav_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output lenav_pkg::cmd_t  head_cmd
);

  lenav_pkg::cmd_t entries [2];
  logic            wr_ptr;
  logic            rd_ptr;
  logic [1:0]      count;
  logic [1:0]      count_next;

  assign full     = (count == 2'd2);
  assign valid    = (count != 2'd0);
  assign head_cmd = entries[rd_ptr];

  always_comb begin
    count_next = count;
    case ({push, pop})
      2'b10:   count_next = count + 2'd1;
      2'b01:   count_next = count - 2'd1;
      default: count_next = count;
    endcase
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count_next;
    end
  end

  // Store entry
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

/* src/lenav_back.sv */
// ----------------------------------------------------------------------------
// lenav_back
// Carries out editing operations on the line memory and streams the line.
// ----------------------------------------------------------------------------
module lenav_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  lenav_pkg::cmd_t       q_cmd,
  output logic                  q_pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [31:0]           m_tdata,
  output logic                  m_tlast
);

  localparam int PW = lenav_pkg::POS_W;
  localparam int CW = lenav_pkg::CHAR_W;

  // Line memory and space map mirror
  logic [CW-1:0]                    text_mem [lenav_pkg::LINE_CAPACITY];
  logic [lenav_pkg::LINE_CAPACITY-1:0] sp_map;
  logic [CW-1:0]                    rdata;
  logic                             mem_we;
  logic [PW-1:0]                    mem_waddr;
  logic [CW-1:0]                    mem_wdata;
  logic                             mem_re;
  logic [PW-1:0]                    mem_raddr;

  // Sequencer state
  lenav_pkg::state_t state, state_next;
  lenav_pkg::op_t    op, op_next;
  logic [CW-1:0]     ch, ch_next;
  logic [PW-1:0]     length, length_next;
  logic [PW-1:0]     cursor, cursor_next;
  logic [PW-1:0]     pos, pos_next;
  logic              phase, phase_next;
  logic [PW-1:0]     idx, idx_next;
  logic              wr_pend, wr_pend_next;
  logic [PW-1:0]     wr_addr, wr_addr_next;

  // Pending read toward the output register
  logic              pend, pend_next;
  logic [PW-1:0]     pend_col, pend_col_next;
  logic              pend_end, pend_end_next;
  logic              pend_last, pend_last_next;

  // Output register
  logic              out_valid;
  logic [PW-1:0]     out_col;
  logic [CW-1:0]     out_glyph;
  logic              out_at_cur;
  logic [PW-1:0]     out_len;
  logic [PW-1:0]     out_cur;
  logic              out_last;

  // Helpers
  logic [PW-1:0]     pos_m1;
  logic [PW-1:0]     span;
  logic              left_mode;
  logic              can_step;
  logic              scan_done;
  logic              end_cell;
  logic              emit_more;
  logic              load;
  logic              issue;

  assign pos_m1    = pos - 1'b1;
  assign span      = cursor - pos;
  assign left_mode = (op != lenav_pkg::OP_WORD_RIGHT);
  assign end_cell  = (cursor == length);
  assign emit_more = (idx < length) || (end_cell && (idx == length));
  assign load      = pend && (!out_valid || m_tready);
  assign issue     = (state == lenav_pkg::ST_EMIT) && emit_more && (!pend || load);

  // Step test of the word scan: phase 0 skips one class, phase 1 the other
  always_comb begin
    if (left_mode) begin
      can_step = (pos != '0) && (sp_map[pos_m1] == ~phase);
    end else begin
      can_step = (pos < length) && (sp_map[pos] == phase);
    end
  end
  assign scan_done = !can_step && phase;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      lenav_pkg::ST_IDLE: begin
        if (q_valid) begin
          case (q_cmd.op)
            lenav_pkg::OP_INSERT:
              state_next = (length != lenav_pkg::CAP_POS) ? lenav_pkg::ST_SHIFT
                                                           : lenav_pkg::ST_EMIT;
            lenav_pkg::OP_DEL_CHAR:
              state_next = (cursor != '0) ? lenav_pkg::ST_REMOVE : lenav_pkg::ST_EMIT;
            lenav_pkg::OP_DEL_WORD:
              state_next = (cursor != '0) ? lenav_pkg::ST_SCAN : lenav_pkg::ST_EMIT;
            lenav_pkg::OP_WORD_LEFT,
            lenav_pkg::OP_WORD_RIGHT:
              state_next = lenav_pkg::ST_SCAN;
            default:
              state_next = lenav_pkg::ST_EMIT;
          endcase
        end
      end
      lenav_pkg::ST_SCAN: begin
        if (scan_done) begin
          if (op != lenav_pkg::OP_DEL_WORD || pos == cursor) begin
            state_next = lenav_pkg::ST_EMIT;
          end else begin
            state_next = lenav_pkg::ST_REMOVE;
          end
        end
      end
      lenav_pkg::ST_SHIFT: begin
        if (idx == cursor && !wr_pend) state_next = lenav_pkg::ST_PUT;
      end
      lenav_pkg::ST_PUT: begin
        state_next = lenav_pkg::ST_EMIT;
      end
      lenav_pkg::ST_REMOVE: begin
        if (idx == length && !wr_pend) state_next = lenav_pkg::ST_EMIT;
      end
      lenav_pkg::ST_EMIT: begin
        if (!emit_more && !pend) state_next = lenav_pkg::ST_IDLE;
      end
      default: state_next = lenav_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    op_next        = op;
    ch_next        = ch;
    length_next    = length;
    cursor_next    = cursor;
    pos_next       = pos;
    phase_next     = phase;
    idx_next       = idx;
    wr_pend_next   = 1'b0;
    wr_addr_next   = wr_addr;
    mem_we         = 1'b0;
    mem_waddr      = wr_addr;
    mem_wdata      = rdata;
    mem_re         = 1'b0;
    mem_raddr      = idx;
    q_pop          = 1'b0;
    pend_next      = load ? 1'b0 : pend;
    pend_col_next  = pend_col;
    pend_end_next  = pend_end;
    pend_last_next = pend_last;

    case (state)
      lenav_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          op_next    = q_cmd.op;
          ch_next    = q_cmd.ch;
          pos_next   = cursor;
          phase_next = 1'b0;
          idx_next   = '0;
          case (q_cmd.op)
            lenav_pkg::OP_INSERT: begin
              if (length != lenav_pkg::CAP_POS) idx_next = length;
            end
            lenav_pkg::OP_DEL_CHAR: begin
              if (cursor != '0) begin
                pos_next = cursor - 1'b1;
                idx_next = cursor;
              end
            end
            lenav_pkg::OP_LEFT: begin
              if (cursor != '0) cursor_next = cursor - 1'b1;
            end
            lenav_pkg::OP_RIGHT: begin
              if (cursor != length) cursor_next = cursor + 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Walk the space map one cell a cycle
      lenav_pkg::ST_SCAN: begin
        if (can_step) begin
          pos_next = left_mode ? pos_m1 : (pos + 1'b1);
        end else if (!phase) begin
          phase_next = 1'b1;
        end else if (op != lenav_pkg::OP_DEL_WORD) begin
          cursor_next = pos;
          idx_next    = '0;
        end else begin
          idx_next = (pos == cursor) ? '0 : cursor;
        end
      end

      // Move the tail one cell right, top down
      lenav_pkg::ST_SHIFT: begin
        mem_we = wr_pend;
        if (idx != cursor) begin
          mem_re       = 1'b1;
          mem_raddr    = idx - 1'b1;
          wr_pend_next = 1'b1;
          wr_addr_next = idx;
          idx_next     = idx - 1'b1;
        end
      end

      // Drop the new character into the gap
      lenav_pkg::ST_PUT: begin
        mem_we      = 1'b1;
        mem_waddr   = cursor;
        mem_wdata   = ch;
        length_next = length + 1'b1;
        cursor_next = cursor + 1'b1;
        idx_next    = '0;
      end

      // Close the gap from pos up to the old cursor, bottom up
      lenav_pkg::ST_REMOVE: begin
        mem_we = wr_pend;
        if (idx != length) begin
          mem_re       = 1'b1;
          mem_raddr    = idx;
          wr_pend_next = 1'b1;
          wr_addr_next = idx - span;
          idx_next     = idx + 1'b1;
        end else if (!wr_pend) begin
          length_next = length - span;
          cursor_next = pos;
          idx_next    = '0;
        end
      end

      // Read cells in order, then the end cell when the cursor sits there
      lenav_pkg::ST_EMIT: begin
        if (issue) begin
          pend_next = 1'b1;
          idx_next  = idx + 1'b1;
          pend_col_next = idx;
          if (idx < length) begin
            mem_re         = 1'b1;
            mem_raddr      = idx;
            pend_end_next  = 1'b0;
            pend_last_next = !end_cell && ((idx + 1'b1) == length);
          end else begin
            pend_end_next  = 1'b1;
            pend_last_next = 1'b1;
          end
        end
      end

      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lenav_pkg::ST_IDLE;
      length    <= '0;
      cursor    <= '0;
      wr_pend   <= 1'b0;
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      length  <= length_next;
      cursor  <= cursor_next;
      wr_pend <= wr_pend_next;
      pend    <= pend_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    op        <= op_next;
    ch        <= ch_next;
    pos       <= pos_next;
    phase     <= phase_next;
    idx       <= idx_next;
    wr_addr   <= wr_addr_next;
    pend_col  <= pend_col_next;
    pend_end  <= pend_end_next;
    pend_last <= pend_last_next;
    if (load) begin
      out_col    <= pend_col;
      out_glyph  <= pend_end ? lenav_pkg::SPACE_CODE : rdata;
      out_at_cur <= (pend_col == cursor);
      out_len    <= length;
      out_cur    <= cursor;
      out_last   <= pend_last;
    end
  end

  // Line memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      text_mem[mem_waddr] <= mem_wdata;
      sp_map[mem_waddr]   <= (mem_wdata == lenav_pkg::SPACE_CODE);
    end
    if (mem_re) rdata <= text_mem[mem_raddr];
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_last;
  assign m_tdata  = {6'd0, out_cur, out_len, out_at_cur, out_glyph, out_col};

endmodule
